/* rtl/pdl_pkg.sv */
package pdl_pkg;

    localparam int POS_W  = 32;
    localparam int GAIN_W = 32;
    localparam int DUTY_W = 14;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 64;
    localparam int CHAN_W = DUTY_W + FRAC_W;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    localparam int DEBOUNCE_SAMPLES = 5;

    localparam logic [DUTY_W-1:0] FULL_DUTY     = DUTY_W'(10000);
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = DUTY_W'(10000);
    localparam logic [CHAN_W-1:0] STOP_THRESHOLD = CHAN_W'(10) << FRAC_W;

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_POSITION   = 3'd0,
        REG_P_GAIN            = 3'd1,
        REG_D_GAIN            = 3'd2,
        REG_MAX_DUTY          = 3'd3,
        REG_LIMITS_ENABLED    = 3'd4,
        REG_SWITCH_ACTIVE_LOW = 3'd5,
        REG_RUN_ENABLE        = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    min_switch_level;
        logic                    max_switch_level;
    } sample_t;

    typedef struct packed {
        logic [DUTY_W-1:0] reverse_duty;
        logic [DUTY_W-1:0] forward_duty;
        logic              limit_stop;
        logic              min_limit_active;
        logic              max_limit_active;
    } result_t;

    typedef struct packed {
        logic signed [POS_W-1:0] target_position;
        logic [GAIN_W-1:0]       p_gain;
        logic [GAIN_W-1:0]       d_gain;
        logic [DUTY_W-1:0]       max_duty;
        logic                    limits_enabled;
        logic                    switch_active_low;
        logic                    run_enable;
    } cfg_t;

    // Products and flags handed from the multiply stage to the output stage
    typedef struct packed {
        logic [PROD_W-1:0] p_mag;
        logic              p_neg;
        logic [PROD_W-1:0] d_mag;
        logic              d_neg;
        logic              min_on;
        logic              max_on;
        logic              run;
    } prod_t;

endpackage

/* rtl/pdl_cfg.sv */
module pdl_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pdl_pkg::IDX_W-1:0]           cfg_index,
    input  logic [pdl_pkg::CFG_W-1:0]           cfg_data,
    output pdl_pkg::cfg_t                       cfg
);

    pdl_pkg::cfg_t cfg_reg;
    pdl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pdl_pkg::REG_TARGET_POSITION:
                    cfg_next.target_position = cfg_data[pdl_pkg::POS_W-1:0];
                pdl_pkg::REG_P_GAIN:
                    cfg_next.p_gain = cfg_data[pdl_pkg::GAIN_W-1:0];
                pdl_pkg::REG_D_GAIN:
                    cfg_next.d_gain = cfg_data[pdl_pkg::GAIN_W-1:0];
                pdl_pkg::REG_MAX_DUTY:
                    cfg_next.max_duty = cfg_data[pdl_pkg::DUTY_W-1:0];
                pdl_pkg::REG_LIMITS_ENABLED:
                    cfg_next.limits_enabled = cfg_data[0];
                pdl_pkg::REG_SWITCH_ACTIVE_LOW:
                    cfg_next.switch_active_low = cfg_data[0];
                pdl_pkg::REG_RUN_ENABLE:
                    cfg_next.run_enable = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                   <= '0;
            cfg_reg.max_duty          <= pdl_pkg::MAX_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/pdl_front.sv */
module pdl_front
#(
    parameter int DEBOUNCE_SAMPLES = pdl_pkg::DEBOUNCE_SAMPLES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pdl_pkg::cfg_t    cfg,
    input  pdl_pkg::sample_t sample_in,
    input  logic             load,
    input  logic             drain,
    output logic             prod_valid,
    output pdl_pkg::prod_t   prod
);

    localparam int CNT_W = $clog2(DEBOUNCE_SAMPLES + 1);
    localparam logic [CNT_W:0]   DEB_FULL  = (CNT_W + 1)'(DEBOUNCE_SAMPLES);
    localparam logic [CNT_W-1:0] DEB_SAT   = CNT_W'(DEBOUNCE_SAMPLES);

    logic signed [pdl_pkg::POS_W-1:0] last_position_reg, last_position_next;
    logic                             have_last_reg, have_last_next;
    logic [CNT_W-1:0]                 min_count_reg, min_count_next;
    logic [CNT_W-1:0]                 max_count_reg, max_count_next;
    logic                             prod_valid_reg, prod_valid_next;
    pdl_pkg::prod_t                   prod_reg, prod_next;

    logic [pdl_pkg::POS_W:0]   err;
    logic [pdl_pkg::POS_W:0]   change;
    logic [pdl_pkg::POS_W-1:0] err_mag;
    logic [pdl_pkg::POS_W-1:0] change_mag;
    logic                      err_neg;
    logic                      change_neg;
    logic                      min_act, max_act;
    logic [CNT_W:0]            min_inc, max_inc;
    logic                      min_hit, max_hit;

    always_comb
    begin
        err = {cfg.target_position[pdl_pkg::POS_W-1], cfg.target_position}
            - {sample_in.position[pdl_pkg::POS_W-1], sample_in.position};
        err_neg = err[pdl_pkg::POS_W];
        err_mag = err_neg ? pdl_pkg::POS_W'(-err) : err[pdl_pkg::POS_W-1:0];

        if (have_last_reg)
            change = {sample_in.position[pdl_pkg::POS_W-1], sample_in.position}
                   - {last_position_reg[pdl_pkg::POS_W-1], last_position_reg};
        else
            change = '0;
        change_neg = change[pdl_pkg::POS_W];
        change_mag = change_neg ? pdl_pkg::POS_W'(-change) : change[pdl_pkg::POS_W-1:0];

        // debounce: count up while active, saturate, clear when released
        min_act = sample_in.min_switch_level ^ cfg.switch_active_low;
        max_act = sample_in.max_switch_level ^ cfg.switch_active_low;
        min_inc = {1'b0, min_count_reg} + 1'b1;
        max_inc = {1'b0, max_count_reg} + 1'b1;
        min_hit = min_act && (min_inc >= DEB_FULL);
        max_hit = max_act && (max_inc >= DEB_FULL);
    end

    always_comb
    begin
        last_position_next = last_position_reg;
        have_last_next     = have_last_reg;
        min_count_next     = min_count_reg;
        max_count_next     = max_count_reg;
        if (load && cfg.run_enable)
        begin
            last_position_next = sample_in.position;
            have_last_next     = 1'b1;
            if (cfg.limits_enabled)
            begin
                min_count_next = !min_act ? '0 : (min_hit ? DEB_SAT : min_inc[CNT_W-1:0]);
                max_count_next = !max_act ? '0 : (max_hit ? DEB_SAT : max_inc[CNT_W-1:0]);
            end
        end

        prod_next        = prod_reg;
        if (load)
        begin
            prod_next.p_mag  = pdl_pkg::PROD_W'(err_mag) * pdl_pkg::PROD_W'(cfg.p_gain);
            prod_next.p_neg  = err_neg;
            prod_next.d_mag  = pdl_pkg::PROD_W'(change_mag) * pdl_pkg::PROD_W'(cfg.d_gain);
            // the damping term is subtracted, so it opposes a positive change
            prod_next.d_neg  = !change_neg && (change != '0);
            prod_next.min_on = cfg.run_enable && cfg.limits_enabled && min_hit;
            prod_next.max_on = cfg.run_enable && cfg.limits_enabled && max_hit;
            prod_next.run    = cfg.run_enable;
        end

        if (load)
            prod_valid_next = 1'b1;
        else if (drain)
            prod_valid_next = 1'b0;
        else
            prod_valid_next = prod_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_position_reg <= '0;
            have_last_reg     <= 1'b0;
            min_count_reg     <= '0;
            max_count_reg     <= '0;
            prod_valid_reg    <= 1'b0;
        end
        else
        begin
            last_position_reg <= last_position_next;
            have_last_reg     <= have_last_next;
            min_count_reg     <= min_count_next;
            max_count_reg     <= max_count_next;
            prod_valid_reg    <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

    a_min_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        min_count_reg <= DEB_SAT)
        else $error("min debounce count above saturation");

    a_max_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        max_count_reg <= DEB_SAT)
        else $error("max debounce count above saturation");

    a_have_last_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        have_last_reg |=> have_last_reg)
        else $error("have_last cleared without reset");

    a_state_held_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.run_enable |=> $stable(last_position_reg) && $stable(min_count_reg))
        else $error("state changed while run disabled");

endmodule

/* rtl/pdl_back.sv */
module pdl_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  pdl_pkg::cfg_t     cfg,
    input  pdl_pkg::prod_t    prod,
    input  logic              load,
    input  logic              result_ready,
    output logic              result_valid,
    output pdl_pkg::result_t  result
);

    logic              result_valid_reg, result_valid_next;
    pdl_pkg::result_t  result_reg, result_next;

    logic [pdl_pkg::PROD_W:0]   sum;
    logic [pdl_pkg::PROD_W:0]   diff;
    logic [pdl_pkg::PROD_W-1:0] drive_mag;
    logic                       drive_neg;
    logic [pdl_pkg::DUTY_W-1:0] limit;
    logic [pdl_pkg::CHAN_W-1:0] ceiling;
    logic [pdl_pkg::CHAN_W-1:0] chan;
    logic [pdl_pkg::CHAN_W-1:0] rev;
    logic [pdl_pkg::CHAN_W-1:0] fwd;
    logic                       stop;

    always_comb
    begin
        sum  = {1'b0, prod.p_mag} + {1'b0, prod.d_mag};
        diff = {1'b0, prod.p_mag} - {1'b0, prod.d_mag};

        if (prod.p_neg == prod.d_neg)
        begin
            // saturate the magnitude on carry out
            drive_mag = sum[pdl_pkg::PROD_W] ? '1 : sum[pdl_pkg::PROD_W-1:0];
            drive_neg = prod.p_neg;
        end
        else if (!diff[pdl_pkg::PROD_W])
        begin
            drive_mag = diff[pdl_pkg::PROD_W-1:0];
            drive_neg = prod.p_neg;
        end
        else
        begin
            drive_mag = pdl_pkg::PROD_W'(-diff);
            drive_neg = prod.d_neg;
        end

        limit   = (cfg.max_duty > pdl_pkg::FULL_DUTY) ? pdl_pkg::FULL_DUTY : cfg.max_duty;
        ceiling = {limit, {pdl_pkg::FRAC_W{1'b0}}};
        chan    = (drive_mag > pdl_pkg::PROD_W'(ceiling))
                ? ceiling : drive_mag[pdl_pkg::CHAN_W-1:0];

        rev = (drive_neg && drive_mag != '0) ? chan : '0;
        fwd = (!drive_neg && drive_mag != '0) ? chan : '0;

        stop = (prod.min_on && rev > pdl_pkg::STOP_THRESHOLD)
            || (prod.max_on && fwd > pdl_pkg::STOP_THRESHOLD);

        result_next = result_reg;
        if (load)
        begin
            result_next = '0;
            if (prod.run)
            begin
                result_next.reverse_duty     = stop ? '0 : rev[pdl_pkg::CHAN_W-1:pdl_pkg::FRAC_W];
                result_next.forward_duty     = stop ? '0 : fwd[pdl_pkg::CHAN_W-1:pdl_pkg::FRAC_W];
                result_next.limit_stop       = stop;
                result_next.min_limit_active = prod.min_on;
                result_next.max_limit_active = prod.max_on;
            end
        end

        if (load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_stop_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.limit_stop |->
            result.reverse_duty == '0 && result.forward_duty == '0)
        else $error("limit stop with nonzero duty");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.reverse_duty == '0 || result.forward_duty == '0)
        else $error("both channels driven");

    a_duty_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.reverse_duty <= pdl_pkg::FULL_DUTY
            && result.forward_duty <= pdl_pkg::FULL_DUTY)
        else $error("duty above full scale");

endmodule

/* rtl/pd_position_loop_with_limit_interlock.sv */
// PD position loop with limit switch interlock.
//
// Each sample word on the sample channel (valid/ready) carries the encoder
// position and the raw min/max limit switch levels. For every accepted word
// the block returns one result word on the result channel (valid/ready):
// reverse and forward duty in hundredths of a percent, the interlock flag and
// the debounced limit flags. Gains, target and limits are set on the cfg write port
// (cfg_we, cfg_index, cfg_data) while no sample is in flight; the user, not the block, ensures it.
//
// Three register stages: input register, multiply register (one 32x32
// product per term), output register. A sample is accepted into the input
// register and passes through the multiply register to the output register;
// one sample per cycle is sustained while the receiver takes results, since each
// stage hands its word on whenever the next is free. When the receiver stalls,
// each stage holds its word and ready falls only once all three stages are full.
// Reset clears the configuration (max_duty to full scale), the previous
// position, the debounce counters and all valid flags; the first running
// sample after reset sees a position change of zero.
module pd_position_loop_with_limit_interlock
#(
    parameter int DEBOUNCE_SAMPLES = pdl_pkg::DEBOUNCE_SAMPLES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  pdl_pkg::sample_t              sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output pdl_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [pdl_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pdl_pkg::CFG_W-1:0]     cfg_data
);

    pdl_pkg::cfg_t    cfg;
    pdl_pkg::prod_t   prod;
    pdl_pkg::sample_t in_reg, in_next;
    logic             in_valid_reg, in_valid_next;
    logic             prod_valid;
    logic             out_free;
    logic             prod_free;
    logic             in_free;
    logic             load_prod;
    logic             load_out;

    // ready ripples back from the output register
    assign out_free  = !result_valid || result_ready;
    assign prod_free = !prod_valid || out_free;
    assign in_free   = !in_valid_reg || prod_free;
    assign load_prod = in_valid_reg && prod_free;
    assign load_out  = prod_valid && out_free;
    assign sample_ready = in_free;

    always_comb
    begin
        in_next = in_reg;
        if (sample_valid && in_free)
            in_next = sample;

        if (sample_valid && in_free)
            in_valid_next = 1'b1;
        else if (load_prod)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
    end

    pdl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdl_front
    #(
        .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample_in  (in_reg),
        .load       (load_prod),
        .drain      (load_out),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    pdl_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .prod         (prod),
        .load         (load_out),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

    a_full_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && prod_valid && result_valid && !result_ready |-> !sample_ready)
        else $error("accepting into a full pipeline");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> result_valid)
        else $error("product stage drained without result");

    a_pass_on: assert property (@(posedge clk) disable iff (!rst_n)
        load_prod |=> prod_valid)
        else $error("input stage drained without product");

endmodule
